FILE: sv/multibulk_request_parser_top_assert.svh
// Assertion macros used by the parser top level.
`ifndef MULTIBULK_REQUEST_PARSER_TOP_ASSERT_SVH
`define MULTIBULK_REQUEST_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define MBRP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low
`define MBRP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mbrp_pkg.sv
`default_nettype none

package mbrp_pkg;

    // Framing characters
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    // Number accumulator saturation value
    localparam int unsigned ACC_W   = 17;
    localparam int unsigned ACC_SAT = 131071;

    // Largest count and length the widths can carry
    localparam int unsigned CNT_HARD_CAP = 256;
    localparam int unsigned LEN_HARD_CAP = 65535;

    // Configuration register indexes
    localparam logic CFG_COUNT_LIMIT  = 1'b0;
    localparam logic CFG_LENGTH_LIMIT = 1'b1;

    typedef enum logic [3:0] {
        PH_STAR    = 4'd0,
        PH_CNT_DIG = 4'd1,
        PH_CNT_LF  = 4'd2,
        PH_DOLLAR  = 4'd3,
        PH_LEN_DIG = 4'd4,
        PH_LEN_LF  = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_PAY_CR  = 4'd7,
        PH_PAY_LF  = 4'd8
    } t_phase;

    typedef enum logic [2:0] {
        E_NONE    = 3'd0,
        E_LEAD    = 3'd1,
        E_DIGIT   = 3'd2,
        E_ZCOUNT  = 3'd3,
        E_ZLEN    = 3'd4,
        E_LIMIT   = 3'd5,
        E_CRLF    = 3'd6,
        E_DISCARD = 3'd7
    } t_err;

    // Effective limits handed to the parser core
    typedef struct packed {
        logic [8:0]  count_limit;
        logic [15:0] length_limit;
    } t_limits;

    // One result item
    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic [7:0] arg_number;
        logic       arg_end;
        logic       request_done;
        t_err       error_code;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/mbrp_core.sv
`default_nettype none

module mbrp_core (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_step,
    input  wire logic [7:0]       i_byte,
    input  wire logic             i_new_conn,
    input  wire mbrp_pkg::t_limits i_limits,
    output mbrp_pkg::t_result     o_result
);
    import mbrp_pkg::*;

    // Parser state
    t_phase           r_phase, n_phase;
    logic             r_failed, n_failed;
    logic [8:0]       r_arg_total, n_arg_total;
    logic [7:0]       r_arg_current, n_arg_current;
    logic [ACC_W-1:0] r_accum, n_accum;
    logic             r_digits, n_digits;
    logic [15:0]      r_bytes_left, n_bytes_left;

    // State as seen by this item: a new connection clears it first
    t_phase           w_phase;
    logic             w_failed;
    logic [8:0]       w_arg_total;
    logic [7:0]       w_arg_current;
    logic [ACC_W-1:0] w_accum;
    logic             w_digits;
    logic [15:0]      w_bytes_left;

    logic             w_is_digit;
    logic [20:0]      w_acc_wide;
    logic [ACC_W-1:0] w_acc_next;
    logic [8:0]       w_cur_inc;
    logic             w_last_arg;
    logic             w_last_byte;
    t_err             w_err;

    always_comb begin
        if (i_new_conn) begin
            w_phase       = PH_STAR;
            w_failed      = 1'b0;
            w_arg_total   = '0;
            w_arg_current = '0;
            w_accum       = '0;
            w_digits      = 1'b0;
            w_bytes_left  = '0;
        end else begin
            w_phase       = r_phase;
            w_failed      = r_failed;
            w_arg_total   = r_arg_total;
            w_arg_current = r_arg_current;
            w_accum       = r_accum;
            w_digits      = r_digits;
            w_bytes_left  = r_bytes_left;
        end
    end

    // Decimal accumulate with saturation: acc*10 + digit
    assign w_is_digit  = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign w_acc_wide  = ({4'b0, w_accum} << 3) + ({4'b0, w_accum} << 1)
                       + {17'b0, i_byte[3:0]};
    assign w_acc_next  = (w_acc_wide > 21'(ACC_SAT)) ? ACC_W'(ACC_SAT)
                                                      : w_acc_wide[ACC_W-1:0];
    assign w_cur_inc   = {1'b0, w_arg_current} + 9'd1;
    assign w_last_arg  = (w_cur_inc >= w_arg_total);
    assign w_last_byte = (w_bytes_left <= 16'd1);

    // Error detection
    always_comb begin
        w_err = E_NONE;
        if (w_failed) begin
            w_err = E_DISCARD;
        end else begin
            unique case (w_phase)
                PH_STAR: begin
                    if (i_byte != CH_STAR) w_err = E_LEAD;
                end
                PH_DOLLAR: begin
                    if (i_byte != CH_DOLLAR) w_err = E_LEAD;
                end
                PH_CNT_DIG, PH_LEN_DIG: begin
                    if (!w_is_digit && !((i_byte == CH_CR) && w_digits)) w_err = E_DIGIT;
                end
                PH_CNT_LF: begin
                    priority if (i_byte != CH_LF)              w_err = E_DIGIT;
                    else if (w_accum == '0)                     w_err = E_ZCOUNT;
                    else if (w_accum > {8'b0, i_limits.count_limit}) w_err = E_LIMIT;
                end
                PH_LEN_LF: begin
                    priority if (i_byte != CH_LF)              w_err = E_DIGIT;
                    else if (w_accum == '0)                     w_err = E_ZLEN;
                    else if (w_accum > {1'b0, i_limits.length_limit}) w_err = E_LIMIT;
                end
                PH_PAYLOAD: ;
                PH_PAY_CR: begin
                    if (i_byte != CH_CR) w_err = E_CRLF;
                end
                PH_PAY_LF: begin
                    if (i_byte != CH_LF) w_err = E_CRLF;
                end
                default: w_err = E_DIGIT;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_phase       = w_phase;
        n_failed      = w_failed;
        n_arg_total   = w_arg_total;
        n_arg_current = w_arg_current;
        n_accum       = w_accum;
        n_digits      = w_digits;
        n_bytes_left  = w_bytes_left;
        if (w_err != E_NONE) begin
            n_failed = 1'b1;
        end else begin
            unique case (w_phase)
                PH_STAR, PH_DOLLAR: begin
                    n_accum  = '0;
                    n_digits = 1'b0;
                    n_phase  = (w_phase == PH_STAR) ? PH_CNT_DIG : PH_LEN_DIG;
                end
                PH_CNT_DIG, PH_LEN_DIG: begin
                    if (w_is_digit) begin
                        n_accum  = w_acc_next;
                        n_digits = 1'b1;
                    end else begin
                        n_phase = (w_phase == PH_CNT_DIG) ? PH_CNT_LF : PH_LEN_LF;
                    end
                end
                PH_CNT_LF: begin
                    // count already checked against a limit of at most 256
                    n_arg_total   = w_accum[8:0];
                    n_arg_current = '0;
                    n_phase       = PH_DOLLAR;
                end
                PH_LEN_LF: begin
                    n_bytes_left = w_accum[15:0];
                    n_phase      = PH_PAYLOAD;
                end
                PH_PAYLOAD: begin
                    if (w_last_byte) begin
                        n_bytes_left = '0;
                        n_phase      = PH_PAY_CR;
                    end else begin
                        n_bytes_left = w_bytes_left - 16'd1;
                    end
                end
                PH_PAY_CR: n_phase = PH_PAY_LF;
                PH_PAY_LF: begin
                    if (w_last_arg) begin
                        n_arg_current = '0;
                        n_arg_total   = '0;
                        n_phase       = PH_STAR;
                    end else begin
                        n_arg_current = w_cur_inc[7:0];
                        n_phase       = PH_DOLLAR;
                    end
                end
                default: n_failed = 1'b1;
            endcase
        end
    end

    // Result item
    always_comb begin
        o_result            = '0;
        o_result.error_code = w_err;
        if (w_err == E_NONE) begin
            unique case (w_phase)
                PH_PAYLOAD: begin
                    o_result.payload_byte  = i_byte;
                    o_result.payload_valid = 1'b1;
                    o_result.arg_number    = w_arg_current;
                    o_result.arg_end       = w_last_byte;
                end
                PH_PAY_LF: o_result.request_done = w_last_arg;
                default: ;
            endcase
        end
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_STAR;
            r_failed      <= 1'b0;
            r_arg_total   <= '0;
            r_arg_current <= '0;
            r_accum       <= '0;
            r_digits      <= 1'b0;
            r_bytes_left  <= '0;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_failed      <= n_failed;
            r_arg_total   <= n_arg_total;
            r_arg_current <= n_arg_current;
            r_accum       <= n_accum;
            r_digits      <= n_digits;
            r_bytes_left  <= n_bytes_left;
        end
    end

endmodule

`default_nettype wire

FILE: sv/multibulk_request_parser_top.sv
// Multibulk request parser. Takes a request stream one byte per item on the
// input channel and returns exactly one result item per byte. A result is a
// payload byte with its argument number and last-byte mark, a done flag on the
// LF that closes a request, an error code, or an empty item for any other
// byte. After an error every byte reports "discarded" until a byte arrives
// with new_connection set. An accepted byte waits in the input register, where
// the parse logic reads it; when the output register is free, the parse state
// is updated and the result lands in the output register at the same edge. A
// new byte is taken every cycle while the output register is free. While a
// result waits to be taken, a byte can still fill an empty input register;
// input ready then follows output ready. The configuration port writes the
// count limit (index 0) and the length limit (index 1). It is always ready.
// The user sees that it is written only while the parser is idle; the block does not enforce it.
`default_nettype none
`include "multibulk_request_parser_top_assert.svh"

module multibulk_request_parser_top #(
    parameter int unsigned MAX_ARGS    = 256,
    parameter int unsigned MAX_ARG_LEN = 65535
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // input channel
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_new_connection,
    // output channel
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_payload_byte,
    output logic             o_payload_valid,
    output logic [7:0]       o_arg_number,
    output logic             o_arg_end,
    output logic             o_request_done,
    output logic [2:0]       o_error_code,
    // configuration write channel
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);
    import mbrp_pkg::*;

    localparam int unsigned CNT_CAP = (MAX_ARGS < CNT_HARD_CAP) ? MAX_ARGS : CNT_HARD_CAP;
    localparam int unsigned LEN_CAP = (MAX_ARG_LEN < LEN_HARD_CAP) ? MAX_ARG_LEN
                                                                     : LEN_HARD_CAP;

    // Configuration registers
    logic [8:0]  r_count_limit;
    logic [15:0] r_length_limit;
    t_limits     w_limits;

    // Input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_new_conn;

    // Output register
    logic        r_out_valid;
    t_result     r_out;
    t_result     w_result;

    logic        w_out_free;
    logic        w_advance;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_limit  <= 9'd64;
            r_length_limit <= 16'd4096;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COUNT_LIMIT:  r_count_limit  <= i_cfg_data[8:0];
                CFG_LENGTH_LIMIT: r_length_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp limits to what the widths and parameters allow
    always_comb begin
        w_limits.count_limit  = (r_count_limit > 9'(CNT_CAP)) ? 9'(CNT_CAP) : r_count_limit;
        w_limits.length_limit = (r_length_limit > 16'(LEN_CAP)) ? 16'(LEN_CAP)
                                                                : r_length_limit;
    end

    // Pipeline flow control
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_in_ready = !r_in_valid || w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_byte     <= i_data_byte;
            r_in_new_conn <= i_new_connection;
        end
    end

    mbrp_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_advance),
        .i_byte     (r_in_byte),
        .i_new_conn (r_in_new_conn),
        .i_limits   (w_limits),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_payload_byte  = r_out.payload_byte;
    assign o_payload_valid = r_out.payload_valid;
    assign o_arg_number    = r_out.arg_number;
    assign o_arg_end       = r_out.arg_end;
    assign o_request_done  = r_out.request_done;
    assign o_error_code    = r_out.error_code;

    // Checks
    `MBRP_ASSERT_IMP(a_err_clears_fields, i_clk, i_rst_n,
        o_out_valid && (o_error_code != E_NONE),
        !o_payload_valid && !o_arg_end && !o_request_done && (o_payload_byte == 8'd0),
        "error result carries payload fields")
    `MBRP_ASSERT_IMP(a_end_needs_payload, i_clk, i_rst_n,
        o_out_valid && o_arg_end, o_payload_valid,
        "arg_end without payload byte")
    `MBRP_ASSERT_IMP(a_done_not_payload, i_clk, i_rst_n,
        o_out_valid && o_request_done, !o_payload_valid,
        "request_done on a payload byte")
    `MBRP_ASSERT_NXT(a_advance_fills_out, i_clk, i_rst_n,
        w_advance, r_out_valid,
        "parsed item did not reach output register")

endmodule

`default_nettype wire

FILE: tb/multibulk_request_parser_top_tb.sv
`timescale 1ns / 100ps

module multibulk_request_parser_top_tb;
    import mbrp_pkg::*;

    localparam int unsigned DUT_MAX_ARGS       = 256;
    localparam int unsigned DUT_MAX_ARG_LEN    = 65535;
    localparam int unsigned RESET_COUNT_LIMIT  = 64;
    localparam int unsigned RESET_LENGTH_LIMIT = 4096;
    localparam int unsigned CYCLE_LIMIT        = 500000;
    localparam int unsigned DRAIN_CYCLES       = 8;
    localparam int unsigned ITEMS_PER_PHASE    = 140;
    localparam int unsigned NUM_PHASES         = 5;
    localparam int unsigned MAX_REPORTS        = 10;
    localparam int unsigned N_DIRECTED         = 25;

    // How a count or length line is written
    typedef enum logic [2:0] {
        NUM_PLAIN,
        NUM_OVER,
        NUM_ZERO,
        NUM_LONG,
        NUM_EMPTY
    } t_num_kind;

    // One directed item, with a typed expectation when fixed is set
    typedef struct packed {
        logic [7:0] data;
        logic       nc;
        logic       fixed;
        t_result    res;
    } t_dir_row;

    localparam t_result NO_RES    = '0;
    localparam t_result R_FF_LAST = '{8'hFF, 1'b1, 8'd0, 1'b1, 1'b0, E_NONE};
    localparam t_result R_DONE    = '{8'h00, 1'b0, 8'd0, 1'b0, 1'b1, E_NONE};
    localparam t_result R_LEAD    = '{8'h00, 1'b0, 8'd0, 1'b0, 1'b0, E_LEAD};
    localparam t_result R_DISCARD = '{8'h00, 1'b0, 8'd0, 1'b0, 1'b0, E_DISCARD};
    localparam t_result R_DIGIT   = '{8'h00, 1'b0, 8'd0, 1'b0, 1'b0, E_DIGIT};
    localparam t_result R_ZCOUNT  = '{8'h00, 1'b0, 8'd0, 1'b0, 1'b0, E_ZCOUNT};
    localparam t_result R_LIMIT   = '{8'h00, 1'b0, 8'd0, 1'b0, 1'b0, E_LIMIT};

    // Directed sequence, run with the reset limits
    localparam t_dir_row [0:N_DIRECTED-1] DIRECTED = '{
        // one-argument request, length with a leading zero, payload byte FF
        '{CH_STAR,   1'b1, 1'b0, NO_RES},
        '{"1",       1'b0, 1'b0, NO_RES},
        '{CH_CR,     1'b0, 1'b0, NO_RES},
        '{CH_LF,     1'b0, 1'b0, NO_RES},
        '{CH_DOLLAR, 1'b0, 1'b0, NO_RES},
        '{"0",       1'b0, 1'b0, NO_RES},
        '{"1",       1'b0, 1'b0, NO_RES},
        '{CH_CR,     1'b0, 1'b0, NO_RES},
        '{CH_LF,     1'b0, 1'b0, NO_RES},
        '{8'hFF,     1'b0, 1'b1, R_FF_LAST},
        '{CH_CR,     1'b0, 1'b0, NO_RES},
        '{CH_LF,     1'b0, 1'b1, R_DONE},
        // bad lead char, then discard until a new connection
        '{8'h00,     1'b0, 1'b1, R_LEAD},
        '{CH_STAR,   1'b0, 1'b1, R_DISCARD},
        // CR with no digit
        '{CH_STAR,   1'b1, 1'b0, NO_RES},
        '{CH_CR,     1'b0, 1'b1, R_DIGIT},
        // zero count
        '{CH_STAR,   1'b1, 1'b0, NO_RES},
        '{"0",       1'b0, 1'b0, NO_RES},
        '{CH_CR,     1'b0, 1'b0, NO_RES},
        '{CH_LF,     1'b0, 1'b1, R_ZCOUNT},
        // count above the reset limit
        '{CH_STAR,   1'b1, 1'b0, NO_RES},
        '{"9",       1'b0, 1'b0, NO_RES},
        '{"9",       1'b0, 1'b0, NO_RES},
        '{CH_CR,     1'b0, 1'b0, NO_RES},
        '{CH_LF,     1'b0, 1'b1, R_LIMIT}
    };

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        i_in_valid       = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte      = 8'h00;
    logic        i_new_connection = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready      = 1'b0;
    logic [7:0]  o_payload_byte;
    logic        o_payload_valid;
    logic [7:0]  o_arg_number;
    logic        o_arg_end;
    logic        o_request_done;
    logic [2:0]  o_error_code;
    logic        i_cfg_valid      = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index      = CFG_COUNT_LIMIT;
    logic [15:0] i_cfg_data       = 16'h0000;

    // Parser tracking state and its copy of the limit registers
    logic [8:0]  lim_count_reg;
    logic [15:0] lim_length_reg;
    t_phase      trk_phase;
    logic        trk_failed;
    logic [8:0]  trk_arg_total;
    logic [7:0]  trk_arg_current;
    logic [16:0] trk_accum;
    logic        trk_digits;
    logic [15:0] trk_bytes_left;

    t_result     pending_results[$];
    logic [7:0]  req_bytes[$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int unsigned cycle_count    = 0;
    int unsigned fail_count     = 0;
    int unsigned sent_items     = 0;
    int unsigned parsed_items   = 0;
    int unsigned done_count     = 0;
    int unsigned error_count    = 0;
    logic        wide_sent      = 1'b0;

    multibulk_request_parser_top #(
        .MAX_ARGS    (DUT_MAX_ARGS),
        .MAX_ARG_LEN (DUT_MAX_ARG_LEN)
    ) i_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void clear_tracker();
        trk_phase       = PH_STAR;
        trk_failed      = 1'b0;
        trk_arg_total   = '0;
        trk_arg_current = '0;
        trk_accum       = '0;
        trk_digits      = 1'b0;
        trk_bytes_left  = '0;
    endfunction

    function automatic int unsigned count_cap();
        int unsigned c;
        c = 32'(lim_count_reg);
        if (c > DUT_MAX_ARGS) begin
            c = DUT_MAX_ARGS;
        end
        if (c > CNT_HARD_CAP) begin
            c = CNT_HARD_CAP;
        end
        return c;
    endfunction

    function automatic int unsigned length_cap();
        int unsigned c;
        c = 32'(lim_length_reg);
        if (c > DUT_MAX_ARG_LEN) begin
            c = DUT_MAX_ARG_LEN;
        end
        return c;
    endfunction

    // One byte of a count or length line
    function automatic t_err digit_step(logic [7:0] b, t_phase lf_phase);
        int unsigned nxt;
        if (b >= CH_ZERO && b <= CH_NINE) begin
            nxt = 32'(trk_accum) * 10 + 32'(b - CH_ZERO);
            trk_accum  = (nxt > ACC_SAT) ? 17'(ACC_SAT) : nxt[16:0];
            trk_digits = 1'b1;
            return E_NONE;
        end
        if (b == CH_CR && trk_digits) begin
            trk_phase = lf_phase;
            return E_NONE;
        end
        return E_DIGIT;
    endfunction

    // Expected result for one accepted byte; advances the tracking state
    function automatic t_result track_parser(logic [7:0] b, logic nc);
        t_result r;
        t_err    err;
        r   = '0;
        err = E_NONE;
        if (nc) begin
            clear_tracker();
        end
        if (trk_failed) begin
            err = E_DISCARD;
        end else begin
            case (trk_phase)
                PH_STAR, PH_DOLLAR: begin
                    if (b == ((trk_phase == PH_STAR) ? CH_STAR : CH_DOLLAR)) begin
                        trk_accum  = '0;
                        trk_digits = 1'b0;
                        trk_phase  = (trk_phase == PH_STAR) ? PH_CNT_DIG : PH_LEN_DIG;
                    end else begin
                        err = E_LEAD;
                    end
                end
                PH_CNT_DIG: err = digit_step(b, PH_CNT_LF);
                PH_LEN_DIG: err = digit_step(b, PH_LEN_LF);
                PH_CNT_LF: begin
                    if (b != CH_LF) begin
                        err = E_DIGIT;
                    end else if (trk_accum == 0) begin
                        err = E_ZCOUNT;
                    end else if (trk_accum > count_cap()) begin
                        err = E_LIMIT;
                    end else begin
                        trk_arg_total   = trk_accum[8:0];
                        trk_arg_current = '0;
                        trk_phase       = PH_DOLLAR;
                    end
                end
                PH_LEN_LF: begin
                    if (b != CH_LF) begin
                        err = E_DIGIT;
                    end else if (trk_accum == 0) begin
                        err = E_ZLEN;
                    end else if (trk_accum > length_cap()) begin
                        err = E_LIMIT;
                    end else begin
                        trk_bytes_left = trk_accum[15:0];
                        trk_phase      = PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    r.payload_byte  = b;
                    r.payload_valid = 1'b1;
                    r.arg_number    = trk_arg_current;
                    if (trk_bytes_left <= 1) begin
                        r.arg_end      = 1'b1;
                        trk_bytes_left = '0;
                        trk_phase      = PH_PAY_CR;
                    end else begin
                        trk_bytes_left = trk_bytes_left - 16'd1;
                    end
                end
                PH_PAY_CR: begin
                    if (b == CH_CR) begin
                        trk_phase = PH_PAY_LF;
                    end else begin
                        err = E_CRLF;
                    end
                end
                PH_PAY_LF: begin
                    if (b != CH_LF) begin
                        err = E_CRLF;
                    end else if (32'(trk_arg_current) + 1 >= 32'(trk_arg_total)) begin
                        r.request_done  = 1'b1;
                        trk_arg_current = '0;
                        trk_arg_total   = '0;
                        trk_phase       = PH_STAR;
                    end else begin
                        trk_arg_current = trk_arg_current + 8'd1;
                        trk_phase       = PH_DOLLAR;
                    end
                end
                default: err = E_DIGIT;
            endcase
            if (err != E_NONE) begin
                trk_failed = 1'b1;
            end
        end
        if (err != E_NONE) begin
            r            = '0;
            r.error_code = err;
        end
        return r;
    endfunction

    function automatic string fmt_res(t_result r);
        return $sformatf("byte=%02h pv=%0b arg=%0d end=%0b done=%0b err=%0d",
                         r.payload_byte, r.payload_valid, r.arg_number, r.arg_end,
                         r.request_done, r.error_code);
    endfunction

    function automatic void log_failure(string msg);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endfunction

    // Result checker
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        got = {o_payload_byte, o_payload_valid, o_arg_number, o_arg_end,
               o_request_done, o_error_code};
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                log_failure({"unexpected result ", fmt_res(got)});
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    log_failure({"expected ", fmt_res(want), " got ", fmt_res(got)});
                end
            end
        end
    end

    // Drives one item; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic nc,
                             input logic fixed, input t_result fixed_res);
        t_result predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_data_byte      <= b;
        i_new_connection <= nc;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = track_parser(b, nc);
        pending_results.push_back(fixed ? fixed_res : predicted);
        sent_items++;
        if (predicted.error_code != E_DISCARD) begin
            parsed_items++;
        end
        if (predicted.request_done) begin
            done_count++;
        end
        if (predicted.error_code != E_NONE && predicted.error_code != E_DISCARD) begin
            error_count++;
        end
        @(negedge i_clk);
    endtask

    // Stop sending and let every outstanding result drain
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_limits(input logic [8:0] cnt, input logic [15:0] len);
        int k;
        for (k = 0; k < 2; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= (k == 0) ? CFG_COUNT_LIMIT : CFG_LENGTH_LIMIT;
            i_cfg_data  <= (k == 0) ? 16'(cnt) : len;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            @(negedge i_clk);
        end
        i_cfg_valid    <= 1'b0;
        lim_count_reg  = cnt;
        lim_length_reg = len;
    endtask

    // Framing characters and digits show up more often than plain noise
    function automatic logic [7:0] junk_byte();
        case ($urandom_range(5))
            0: return CH_CR;
            1: return CH_LF;
            2: return CH_STAR;
            3: return CH_DOLLAR;
            4: return 8'(CH_ZERO + $urandom_range(9));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    // Mostly a legal value, sometimes exactly the limit, else a broken number
    function automatic t_num_kind pick_number(input int unsigned cap,
                                              input int unsigned typ_max,
                                              input int unsigned fault_pct,
                                              output int unsigned value);
        value = $urandom_range(1, (cap < typ_max) ? cap : typ_max);
        if ($urandom_range(99) >= fault_pct) begin
            if (cap <= 2 * typ_max && $urandom_range(7) == 0) begin
                value = cap;
            end
            return NUM_PLAIN;
        end
        case ($urandom_range(3))
            0: begin
                value = cap + 1;
                return NUM_OVER;
            end
            1: begin
                value = 0;
                return NUM_ZERO;
            end
            2: return NUM_LONG;
            default: return NUM_EMPTY;
        endcase
    endfunction

    function automatic void push_number(int unsigned value, t_num_kind kind);
        string s;
        int    n;
        if (kind == NUM_EMPTY) begin
            return;
        end
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) req_bytes.push_back(CH_ZERO);
        end
        if (kind == NUM_LONG) begin
            // at least seven digits, so the accumulator saturates
            req_bytes.push_back(8'(CH_ZERO + $urandom_range(1, 9)));
            repeat ($urandom_range(6, 9)) req_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
        end else begin
            s = $sformatf("%0d", value);
            for (n = 0; n < s.len(); n++) begin
                req_bytes.push_back(s[n]);
            end
        end
        req_bytes.push_back(CH_CR);
        req_bytes.push_back(CH_LF);
    endfunction

    // Builds and sends one request, mostly well formed
    task automatic send_request();
        int unsigned n_args;
        int unsigned n_len;
        int unsigned len_typ;
        int unsigned len_fault;
        int unsigned a;
        int unsigned k;
        int unsigned pos;
        t_num_kind   kind;
        logic        nc;
        req_bytes.delete();
        req_bytes.push_back(CH_STAR);
        kind = pick_number(count_cap(), 4, 15, n_args);
        if (kind == NUM_PLAIN && !wide_sent && count_cap() >= 200 &&
            $urandom_range(29) == 0) begin
            // one wide request so the argument number reaches its upper bits
            n_args    = $urandom_range(129, 136);
            wide_sent = 1'b1;
        end
        push_number(n_args, kind);
        len_typ   = (n_args > 16) ? 2 : 8;
        len_fault = (n_args > 16) ? 0 : 3;
        for (a = 0; kind == NUM_PLAIN && a < n_args; a++) begin
            req_bytes.push_back(CH_DOLLAR);
            kind = pick_number(length_cap(), ($urandom_range(9) == 0) ? 40 : len_typ,
                               len_fault, n_len);
            push_number(n_len, kind);
            if (kind == NUM_PLAIN) begin
                repeat (n_len) req_bytes.push_back(8'($urandom_range(255)));
                req_bytes.push_back(CH_CR);
                req_bytes.push_back(CH_LF);
                // broken payload trailer
                if ($urandom_range(99) < len_fault) begin
                    req_bytes[req_bytes.size() - 1 - $urandom_range(1)] = junk_byte();
                    break;
                end
            end
        end
        // occasional stray, lost or replaced byte
        if ($urandom_range(99) < 8) begin
            pos = $urandom_range(req_bytes.size() - 1);
            case ($urandom_range(2))
                0: req_bytes[pos] = junk_byte();
                1: req_bytes.delete(pos);
                default: req_bytes.insert(pos, junk_byte());
            endcase
        end
        // a failed parser needs a new connection; some noise is discarded first
        if (trk_failed) begin
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 3)) send_byte(junk_byte(), 1'b0, 1'b0, NO_RES);
            end
            nc = 1'b1;
        end else begin
            nc = ($urandom_range(9) == 0);
        end
        for (k = 0; k < req_bytes.size(); k++) begin
            send_byte(req_bytes[k], nc, 1'b0, NO_RES);
            nc = ($urandom_range(99) == 0);
        end
    endtask

    // Run timeout
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d results outstanding",
                 cycle_count, pending_results.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int unsigned i;
        int unsigned ph;
        int unsigned start;
        clear_tracker();
        lim_count_reg  = 9'(RESET_COUNT_LIMIT);
        lim_length_reg = 16'(RESET_LENGTH_LIMIT);
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed items against the reset limits
        for (i = 0; i < N_DIRECTED; i++) begin
            send_byte(DIRECTED[i].data, DIRECTED[i].nc, DIRECTED[i].fixed, DIRECTED[i].res);
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    set_limits(9'd1, 16'd1);
                    send_idle_pct  = 85;
                    recv_stall_pct = 0;
                end
                2: begin
                    set_limits(9'd256, 16'd65535);
                    send_idle_pct  = 0;
                    recv_stall_pct = 85;
                end
                3: begin
                    set_limits(9'($urandom_range(2, 12)), 16'($urandom_range(9, 200)));
                    send_idle_pct  = 18;
                    recv_stall_pct = 18;
                end
                default: begin
                    set_limits(9'($urandom_range(1, 256)), 16'($urandom_range(1, 65535)));
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            start = parsed_items;
            while (parsed_items - start < ITEMS_PER_PHASE) begin
                send_request();
            end
        end
        wait_idle();

        $display("Sent %0d bytes (%0d parsed, rest discarded) under %0d limit settings",
                 sent_items, parsed_items, NUM_PHASES);
        $display("Requests completed: %0d, protocol errors flagged: %0d",
                 done_count, error_count);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
